// File: sv/swps_pkg.sv
`default_nettype none

package swps_pkg;

   // Default width of the tick counters.
   localparam int unsigned TIMER_BITS_DEFAULT = 16;

   localparam int unsigned BLINK_W  = 10;
   localparam int unsigned PAUSE_W  = 12;
   localparam int unsigned UNIT_W   = 8;
   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned MODE_W   = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Product of mode and weld unit: 15 * 255 fits in 12 bits.
   localparam int unsigned PULSE_W = MODE_W + UNIT_W;

   localparam logic [BLINK_W-1:0] BLINK_HALF_RESET = BLINK_W'(250);
   localparam logic [PAUSE_W-1:0] PAUSE_RESET      = PAUSE_W'(1000);
   localparam logic [UNIT_W-1:0]  WELD_UNIT_RESET  = UNIT_W'(10);
   localparam logic [HOLD_W-1:0]  HOLDOFF_RESET    = HOLD_W'(2000);
   localparam logic [MODE_W-1:0]  MAX_MODE_RESET   = MODE_W'(5);
   localparam logic [MODE_W-1:0]  MODE_RESET       = MODE_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLINK_HALF = 3'd0,
      CSR_PAUSE      = 3'd1,
      CSR_WELD_UNIT  = 3'd2,
      CSR_HOLDOFF    = 3'd3,
      CSR_MAX_MODE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [BLINK_W-1:0] blink_half_ticks;
      logic [PAUSE_W-1:0] pause_ticks;
      logic [UNIT_W-1:0]  weld_unit_ticks;
      logic [HOLD_W-1:0]  holdoff_ticks;
      logic [MODE_W-1:0]  max_mode;
   } swps_cfg_type;

   typedef struct packed {
      logic              led_on;
      logic              weld_on;
      logic [MODE_W-1:0] mode_now;
   } swps_result_type;

endpackage

`default_nettype wire

// File: sv/swps_core.sv
`default_nettype none

module swps_core
   import swps_pkg::*;
#(
   parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic            mode_press,
   input  wire logic            weld_press,
   input  wire swps_cfg_type    cfg,
   output swps_result_type      result
);

   localparam int unsigned CMP_W = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   typedef enum logic [1:0] {
      PH_ON    = 2'd0,
      PH_OFF   = 2'd1,
      PH_PAUSE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      WS_IDLE = 2'd0,
      WS_FIRE = 2'd1,
      WS_HOLD = 2'd2
   } stage_type;

   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic                  mode_pend_ff, mode_pend_in;
   logic                  weld_pend_ff, weld_pend_in;
   phase_type             phase_ff, phase_in;
   stage_type             stage_ff, stage_in;
   logic [MODE_W-1:0]     blinks_ff, blinks_in;
   logic [TIMER_BITS-1:0] pcnt_ff, pcnt_in;
   logic [TIMER_BITS-1:0] wcnt_ff, wcnt_in;

   logic [TIMER_BITS-1:0] pcnt_inc, wcnt_inc;
   logic [BLINK_W-1:0]    half;
   logic [UNIT_W-1:0]     unit;
   logic [MODE_W-1:0]     top_mode;
   logic [MODE_W-1:0]     blinks_inc;
   logic [PULSE_W-1:0]    pulse_len;
   logic                  half_done, pause_done, pulse_done, hold_done;
   logic                  weld_on;

   always_comb begin
      half     = (cfg.blink_half_ticks == '0) ? BLINK_W'(1) : cfg.blink_half_ticks;
      unit     = (cfg.weld_unit_ticks == '0) ? UNIT_W'(1) : cfg.weld_unit_ticks;
      top_mode = (cfg.max_mode == '0) ? MODE_W'(1) : cfg.max_mode;
      pcnt_inc   = pcnt_ff + TIMER_BITS'(1);
      wcnt_inc   = wcnt_ff + TIMER_BITS'(1);
      blinks_inc = blinks_ff + MODE_W'(1);
      pulse_len  = PULSE_W'(mode_ff) * PULSE_W'(unit);
      half_done  = pcnt_inc >= TIMER_BITS'(half);
      pause_done = pcnt_inc >= TIMER_BITS'(cfg.pause_ticks);
      pulse_done = wcnt_inc >= TIMER_BITS'(pulse_len);
      // The hold-off may be wider than the counter; it saturates at full scale.
      hold_done  = (CMP_W'(wcnt_inc) >= CMP_W'(cfg.holdoff_ticks)) || (wcnt_inc == TMAX);
   end

   always_comb begin
      mode_in      = mode_ff;
      mode_pend_in = mode_pend_ff | mode_press;
      weld_pend_in = weld_pend_ff;
      phase_in     = phase_ff;
      stage_in     = stage_ff;
      blinks_in    = blinks_ff;
      pcnt_in      = pcnt_ff;
      wcnt_in      = wcnt_ff;
      weld_on      = 1'b0;

      if (stage_ff == WS_IDLE && weld_pend_ff) begin
         // A pending weld starts now; this tick is its first firing tick.
         weld_pend_in = 1'b0;
         weld_on      = 1'b1;
         if (pulse_len <= PULSE_W'(1)) begin
            wcnt_in  = '0;
            stage_in = (cfg.holdoff_ticks == '0) ? WS_IDLE : WS_HOLD;
         end else begin
            wcnt_in  = TIMER_BITS'(1);
            stage_in = WS_FIRE;
         end
      end else if (stage_ff == WS_FIRE) begin
         weld_on = 1'b1;
         if (pulse_done) begin
            wcnt_in  = '0;
            stage_in = (cfg.holdoff_ticks == '0) ? WS_IDLE : WS_HOLD;
         end else begin
            wcnt_in = wcnt_inc;
         end
      end else if (stage_ff == WS_HOLD) begin
         if (hold_done) begin
            wcnt_in  = '0;
            stage_in = WS_IDLE;
         end else begin
            wcnt_in = wcnt_inc;
         end
      end else begin
         if (weld_press) begin
            weld_pend_in = 1'b1;
         end
         pcnt_in = pcnt_inc;
         case (phase_ff)
            PH_ON: begin
               if (half_done) begin
                  weld_pend_in = 1'b0;
                  phase_in     = PH_OFF;
                  pcnt_in      = '0;
               end
            end
            PH_OFF: begin
               if (half_done) begin
                  weld_pend_in = 1'b0;
                  pcnt_in      = '0;
                  if (blinks_inc >= mode_ff) begin
                     blinks_in = '0;
                     if (cfg.pause_ticks == '0) begin
                        phase_in = PH_ON;
                        if (mode_pend_in) begin
                           mode_in      = (mode_ff >= top_mode) ? MODE_W'(1)
                                                                : mode_ff + MODE_W'(1);
                           mode_pend_in = 1'b0;
                        end
                     end else begin
                        phase_in = PH_PAUSE;
                     end
                  end else begin
                     blinks_in = blinks_inc;
                     phase_in  = PH_ON;
                  end
               end
            end
            default: begin
               if (pause_done) begin
                  weld_pend_in = 1'b0;
                  phase_in     = PH_ON;
                  pcnt_in      = '0;
                  if (mode_pend_in) begin
                     mode_in      = (mode_ff >= top_mode) ? MODE_W'(1)
                                                          : mode_ff + MODE_W'(1);
                     mode_pend_in = 1'b0;
                  end
               end
            end
         endcase
      end
   end

   // Results describe the tick in progress, before the state moves on.
   assign result.led_on   = (phase_ff == PH_ON);
   assign result.weld_on  = weld_on;
   assign result.mode_now = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         mode_pend_ff <= 1'b0;
         weld_pend_ff <= 1'b0;
         phase_ff     <= PH_ON;
         stage_ff     <= WS_IDLE;
         blinks_ff    <= '0;
         pcnt_ff      <= '0;
         wcnt_ff      <= '0;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         mode_pend_ff <= mode_pend_in;
         weld_pend_ff <= weld_pend_in;
         phase_ff     <= phase_in;
         stage_ff     <= stage_in;
         blinks_ff    <= blinks_in;
         pcnt_ff      <= pcnt_in;
         wcnt_ff      <= wcnt_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/spot_weld_pulse_sequencer_top.sv
`default_nettype none

// Spot-weld pulse sequencer. Each request is one 1 ms tick carrying the mode
// and weld button events seen in that tick, and each request yields exactly one
// response: the LED drive, the weld drive and the mode in force during that
// tick. The block accepts a request into a request register, and returns its
// response from a response register; all tick counters and compares update
// combinationally between the request register and the response register,
// so the rate is one request per clock whenever the response side keeps up. The timing
// registers are written through the csr_ port and must only change while no
// request is in flight; their reset values are a 250 tick blink half, a 1000
// tick pause, a 10 tick weld unit, a 2000 tick hold-off and a top mode of 5.
// The mode starts at 3 after reset.

module spot_weld_pulse_sequencer_top
   import swps_pkg::*;
#(
   parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode_press,
   input  wire logic                  req_weld_press,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_led_on,
   output logic                       rsp_weld_on,
   output logic [MODE_W-1:0]          rsp_mode_now,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   swps_cfg_type    cfg_ff;
   swps_result_type result;

   // Request register: holds one tick until the core has consumed it.
   logic in_valid_ff, in_valid_in;
   logic in_mode_ff, in_weld_ff;
   // Response register: holds one result until the consumer takes it.
   logic            out_valid_ff, out_valid_in;
   swps_result_type out_ff;
   logic            advance;

   // The core steps whenever a request is held and the response slot is free
   // or being emptied in this same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode_press;
         in_weld_ff <= req_weld_press;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // Configuration registers. Writes to unused indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_half_ticks <= BLINK_HALF_RESET;
         cfg_ff.pause_ticks      <= PAUSE_RESET;
         cfg_ff.weld_unit_ticks  <= WELD_UNIT_RESET;
         cfg_ff.holdoff_ticks    <= HOLDOFF_RESET;
         cfg_ff.max_mode         <= MAX_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLINK_HALF: cfg_ff.blink_half_ticks <= csr_wdata[BLINK_W-1:0];
            CSR_PAUSE:      cfg_ff.pause_ticks      <= csr_wdata[PAUSE_W-1:0];
            CSR_WELD_UNIT:  cfg_ff.weld_unit_ticks  <= csr_wdata[UNIT_W-1:0];
            CSR_HOLDOFF:    cfg_ff.holdoff_ticks    <= csr_wdata[HOLD_W-1:0];
            CSR_MAX_MODE:   cfg_ff.max_mode         <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   swps_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .mode_press (in_mode_ff),
      .weld_press (in_weld_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_led_on   = out_ff.led_on;
   assign rsp_weld_on  = out_ff.weld_on;
   assign rsp_mode_now = out_ff.mode_now;

endmodule

`default_nettype wire

// File: sv/swps_checker.sv
`default_nettype none

module swps_checker
   import swps_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_led_on,
   input wire logic              rsp_weld_on,
   input wire logic [MODE_W-1:0] rsp_mode_now
);

   logic              have_prev_ff;
   logic [MODE_W-1:0] prev_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         have_prev_ff <= 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         prev_mode_ff <= rsp_mode_now;
      end
   end

   // No response may be pending right after a reset cycle.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the response slot empty the block must take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while response slot empty");

   // The mode only steps forward by one or wraps back to one.
   a_mode_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && have_prev_ff && rsp_mode_now != prev_mode_ff) |->
      (rsp_mode_now == prev_mode_ff + MODE_W'(1) || rsp_mode_now == MODE_W'(1)))
      else $error("mode changed by more than one step");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_led_on) && $stable(rsp_weld_on) && $stable(rsp_mode_now)))
      else $error("stalled response changed");

endmodule

bind spot_weld_pulse_sequencer_top swps_checker u_swps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_led_on   (rsp_led_on),
   .rsp_weld_on  (rsp_weld_on),
   .rsp_mode_now (rsp_mode_now)
);

`default_nettype wire

// File: dv/weld_sequence_checker.sv
// Watches the request, response and register ports of the pulse sequencer,
// keeps its own copy of the tick state and compares every response in order.
module weld_sequence_checker
   import swps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_mode_press,
   input  logic                  req_weld_press,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_led_on,
   input  logic                  rsp_weld_on,
   input  logic [MODE_W-1:0]     rsp_mode_now,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {BLINK_ON, BLINK_OFF, BLINK_PAUSE} blink_phase_type;
   typedef enum logic [1:0] {WELD_IDLE, WELD_FIRE, WELD_HOLD} weld_stage_type;

   swps_cfg_type      timing;
   logic [MODE_W-1:0] cur_mode;
   logic              mode_latched;
   logic              weld_latched;
   blink_phase_type   blink_phase;
   logic [3:0]        blinks_shown;
   logic [15:0]       phase_ticks;
   logic [15:0]       weld_ticks;
   weld_stage_type    stage;

   swps_result_type   expected_ticks[$];
   int                fault_count = 0;
   int                ticks_seen = 0;

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   // A finished blink group: take a latched mode press, then start over.
   function automatic void close_cycle();
      logic [MODE_W-1:0] top_mode;
      top_mode = (timing.max_mode == '0) ? MODE_W'(1) : timing.max_mode;
      if (mode_latched) begin
         cur_mode = (cur_mode >= top_mode) ? MODE_W'(1) : cur_mode + 1'b1;
         mode_latched = 1'b0;
      end
      blink_phase = BLINK_ON;
      phase_ticks = '0;
   endfunction

   function automatic swps_result_type predict_tick(input logic mp, input logic wp);
      swps_result_type res;
      int unsigned     half;
      int unsigned     pulse_len;
      res.led_on = (blink_phase == BLINK_ON);
      res.mode_now = cur_mode;
      if (stage == WELD_IDLE && weld_latched) begin
         weld_latched = 1'b0;
         stage = WELD_FIRE;
         weld_ticks = '0;
      end
      if (mp) begin
         mode_latched = 1'b1;
      end
      if (stage != WELD_IDLE) begin
         res.weld_on = (stage == WELD_FIRE);
         weld_ticks = weld_ticks + 1'b1;
         if (stage == WELD_FIRE) begin
            pulse_len = 32'(cur_mode) *
               ((timing.weld_unit_ticks == '0) ? 32'd1 : 32'(timing.weld_unit_ticks));
            if (32'(weld_ticks) >= pulse_len) begin
               weld_ticks = '0;
               stage = (timing.holdoff_ticks == '0) ? WELD_IDLE : WELD_HOLD;
            end
         end else if (weld_ticks >= timing.holdoff_ticks) begin
            weld_ticks = '0;
            stage = WELD_IDLE;
         end
      end else begin
         res.weld_on = 1'b0;
         if (wp) begin
            weld_latched = 1'b1;
         end
         half = (timing.blink_half_ticks == '0) ? 32'd1 : 32'(timing.blink_half_ticks);
         phase_ticks = phase_ticks + 1'b1;
         case (blink_phase)
            BLINK_ON: begin
               if (32'(phase_ticks) >= half) begin
                  weld_latched = 1'b0;
                  blink_phase = BLINK_OFF;
                  phase_ticks = '0;
               end
            end
            BLINK_OFF: begin
               if (32'(phase_ticks) >= half) begin
                  weld_latched = 1'b0;
                  phase_ticks = '0;
                  blinks_shown = blinks_shown + 1'b1;
                  if (blinks_shown >= cur_mode) begin
                     blinks_shown = '0;
                     if (timing.pause_ticks == '0) begin
                        close_cycle();
                     end else begin
                        blink_phase = BLINK_PAUSE;
                     end
                  end else begin
                     blink_phase = BLINK_ON;
                  end
               end
            end
            default: begin
               if (32'(phase_ticks) >= 32'(timing.pause_ticks)) begin
                  weld_latched = 1'b0;
                  close_cycle();
               end
            end
         endcase
      end
      return res;
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endfunction

   always @(posedge clock) begin : watch
      swps_result_type want;
      if (reset) begin
         timing.blink_half_ticks = BLINK_HALF_RESET;
         timing.pause_ticks = PAUSE_RESET;
         timing.weld_unit_ticks = WELD_UNIT_RESET;
         timing.holdoff_ticks = HOLDOFF_RESET;
         timing.max_mode = MAX_MODE_RESET;
         cur_mode = MODE_RESET;
         mode_latched = 1'b0;
         weld_latched = 1'b0;
         blink_phase = BLINK_ON;
         blinks_shown = '0;
         phase_ticks = '0;
         weld_ticks = '0;
         stage = WELD_IDLE;
         expected_ticks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ticks.size() == 0) begin
               note_fault($sformatf("response led %0b weld %0b mode %0d with no tick pending",
                  rsp_led_on, rsp_weld_on, rsp_mode_now));
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_led_on !== want.led_on || rsp_weld_on !== want.weld_on ||
                     rsp_mode_now !== want.mode_now) begin
                  note_fault($sformatf(
                     "tick %0d expected led %0b weld %0b mode %0d, got led %0b weld %0b mode %0d",
                     ticks_seen, want.led_on, want.weld_on, want.mode_now,
                     rsp_led_on, rsp_weld_on, rsp_mode_now));
               end
            end
            ticks_seen++;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BLINK_HALF: timing.blink_half_ticks = csr_wdata[BLINK_W-1:0];
               CSR_PAUSE:      timing.pause_ticks = csr_wdata[PAUSE_W-1:0];
               CSR_WELD_UNIT:  timing.weld_unit_ticks = csr_wdata[UNIT_W-1:0];
               CSR_HOLDOFF:    timing.holdoff_ticks = csr_wdata[HOLD_W-1:0];
               CSR_MAX_MODE:   timing.max_mode = csr_wdata[MODE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_ticks.push_back(predict_tick(req_mode_press, req_weld_press));
         end
      end
      mismatches <= fault_count;
      outstanding <= expected_ticks.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the verification environment for the spot-weld pulse sequencer.
// This module only produces stimulus and reaches the verdict; checking is
// done by the checker instance beside the block and the assertions bound into it.
module testbench;
   import swps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // A run is declared hung once this many cycles pass with no handshake
   // of any kind. The longest legal quiet stretch is the deliberate
   // response hold-off below, so the limit leaves a wide margin over it.
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD = 200;
   localparam int PHASES = 8;
   localparam int TICKS_PER_PHASE = 85;

   // Directed scripts. The first runs under the reset timing and starts a
   // weld right away, then presses both buttons while it fires. The second
   // runs with every timing register at zero, so that the blink half, the
   // weld unit and the top mode all act as one, and pause and hold-off are
   // skipped. Bit i of each constant is the press for the i-th request.
   localparam logic [5:0]  RESET_MODE_SCRIPT = 6'b011000;
   localparam logic [5:0]  RESET_WELD_SCRIPT = 6'b010101;
   localparam logic [18:0] ZERO_MODE_SCRIPT  = 19'b0100_1001_1000_1100_100;
   localparam logic [18:0] ZERO_WELD_SCRIPT  = 19'b1010_0110_0011_0001_010;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode_press = 1'b0;
   logic                  req_weld_press = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_led_on;
   logic                  rsp_weld_on;
   logic [MODE_W-1:0]     rsp_mode_now;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;

   // Knobs shared between the request side and the response side.
   bit sender_idling = 1'b1;
   bit receiver_idling = 1'b1;
   bit long_hold_request = 1'b0;
   int long_holds_done = 0;

   int requests_sent = 0;
   int mode_presses = 0;
   int weld_presses = 0;
   int settings_loaded = 0;

   always #5ns clock = ~clock;

   spot_weld_pulse_sequencer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode_press (req_mode_press),
      .req_weld_press (req_weld_press),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_on     (rsp_led_on),
      .rsp_weld_on    (rsp_weld_on),
      .rsp_mode_now   (rsp_mode_now),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   weld_sequence_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode_press (req_mode_press),
      .req_weld_press (req_weld_press),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_on     (rsp_led_on),
      .rsp_weld_on    (rsp_weld_on),
      .rsp_mode_now   (rsp_mode_now),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   // Offers one tick request and returns at the edge where it is taken.
   // When sender idling is enabled, a random burst of empty cycles may come
   // first. Valid is only dropped for such a burst, so a valid that stays
   // high across back-to-back requests gets a single update per edge.
   task automatic offer_tick(input logic mp, input logic wp);
      int gap;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode_press <= mp;
      req_weld_press <= wp;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      mode_presses += mp;
      weld_presses += wp;
   endtask

   // Ends a group of requests and waits until every response is back, so
   // that the block is idle before the timing registers change.
   task automatic drain_ticks();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all five timing registers on consecutive edges.
   task automatic load_timing(input swps_cfg_type t);
      put_reg(CSR_BLINK_HALF, CSR_DATA_W'(t.blink_half_ticks));
      put_reg(CSR_PAUSE, CSR_DATA_W'(t.pause_ticks));
      put_reg(CSR_WELD_UNIT, CSR_DATA_W'(t.weld_unit_ticks));
      put_reg(CSR_HOLDOFF, CSR_DATA_W'(t.holdoff_ticks));
      put_reg(CSR_MAX_MODE, CSR_DATA_W'(t.max_mode));
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // The response side alternates random runs of readiness with random
   // stall bursts. On request it also holds off for one long stretch,
   // counting the cycles itself, so that the block fills and stalls its
   // request port while the sender keeps offering.
   initial begin : response_side
      int span;
      forever begin
         if (long_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_request = 1'b0;
            long_holds_done++;
         end else if (receiver_idling && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 16);
            rsp_ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Any handshake restarts the count of quiet cycles.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      swps_cfg_type t;
      int           mode_pct;
      int           weld_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset timing is checked first, without touching any register.
      for (int i = 0; i < 6; i++) begin
         offer_tick(RESET_MODE_SCRIPT[i], RESET_WELD_SCRIPT[i]);
      end
      drain_ticks();

      // With every register at zero, each idle tick ends a blink phase, so
      // a weld press is always dropped and a latched mode press wraps the
      // mode above the top value straight back to one.
      t = '0;
      load_timing(t);
      for (int i = 0; i < 19; i++) begin
         offer_tick(ZERO_MODE_SCRIPT[i], ZERO_WELD_SCRIPT[i]);
      end
      drain_ticks();

      // Random phases. The first uses full-scale values in every register,
      // the second the smallest legal ones, the rest short random timings
      // so that many blink groups, welds and hold-offs fit in each phase.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            t.blink_half_ticks = '1;
            t.pause_ticks = '1;
            t.weld_unit_ticks = '1;
            t.holdoff_ticks = '1;
            t.max_mode = MODE_W'(15);
         end else if (ph == 1) begin
            t.blink_half_ticks = BLINK_W'(1);
            t.pause_ticks = '0;
            t.weld_unit_ticks = UNIT_W'(1);
            t.holdoff_ticks = '0;
            t.max_mode = MODE_W'(1);
         end else begin
            t.blink_half_ticks = BLINK_W'($urandom_range(0, 4));
            t.pause_ticks = PAUSE_W'($urandom_range(0, 8));
            t.weld_unit_ticks = UNIT_W'($urandom_range(0, 3));
            t.holdoff_ticks = HOLD_W'($urandom_range(0, 12));
            t.max_mode = MODE_W'($urandom_range(0, 15));
         end
         load_timing(t);

         // The third phase carries the long response hold-off, with the
         // sender offering without gaps; the last phase has no idling.
         if (ph == 2) begin
            sender_idling = 1'b0;
            receiver_idling = 1'b1;
            long_hold_request = 1'b1;
         end else if (ph == PHASES - 1) begin
            sender_idling = 1'b0;
            receiver_idling = 1'b0;
         end else begin
            sender_idling = ($urandom_range(0, 3) != 0);
            receiver_idling = ($urandom_range(0, 3) != 0);
         end

         mode_pct = $urandom_range(5, 30);
         weld_pct = $urandom_range(5, 30);
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            offer_tick($urandom_range(0, 99) < mode_pct, $urandom_range(0, 99) < weld_pct);
         end
         drain_ticks();
      end

      // Every response is in; a few more cycles catch anything stray that
      // the block might still emit from its request and response registers.
      repeat (8) @(posedge clock);

      $display("Sent %0d tick requests with %0d mode and %0d weld presses over %0d timings,",
         requests_sent, mode_presses, weld_presses, settings_loaded);
      $display("from all-zero to full-scale registers, with %0d long response hold-off(s).",
         long_holds_done);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/swps_pkg.sv
sv/swps_core.sv
sv/spot_weld_pulse_sequencer_top.sv
sv/swps_checker.sv
dv/weld_sequence_checker.sv
dv/testbench.sv
